// ===== sv/ctwc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the counter to wall time clock.
package ctwc_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAIN_MULT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAIN_SHIFT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_MULT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_SHIFT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAIN_MODE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_MODE   = 3'd5;

  // Item functions
  localparam logic [1:0] FUNC_READ    = 2'd0;
  localparam logic [1:0] FUNC_TOD     = 2'd1;
  localparam logic [1:0] FUNC_BASE_WR = 2'd2;
  localparam logic [1:0] FUNC_REF_WR  = 2'd3;

  // Clock numbers
  localparam logic [3:0] CID_REALTIME    = 4'd0;
  localparam logic [3:0] CID_MONOTONIC   = 4'd1;
  localparam logic [3:0] CID_RAW         = 4'd4;
  localparam logic [3:0] CID_RT_COARSE   = 4'd5;
  localparam logic [3:0] CID_MONO_COARSE = 4'd6;
  localparam logic [3:0] CID_BOOTTIME    = 4'd7;
  localparam logic [3:0] CID_TAI         = 4'd11;

  // Divisors
  localparam int         SUB_W     = 30;
  localparam logic [SUB_W-1:0] NS_PER_S  = 30'd1000000000;
  localparam logic [SUB_W-1:0] NS_PER_US = 30'd1000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEM,
    ST_MUL_HI,
    ST_SUM,
    ST_DIV_NS,
    ST_DIV_US,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    KIND_MAIN,
    KIND_RAW,
    KIND_COARSE,
    KIND_NONE
  } kind_e;

  typedef enum logic {
    DIV_BY_S,
    DIV_BY_US
  } div_sel_e;

  typedef struct packed {
    logic     start;
    div_sel_e sel;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== sv/ctwc_if.sv =====
`timescale 1ns / 1ps
// Item channels of the counter to wall time clock: request and result.
interface ctwc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [3:0]  clock_id;
  logic [63:0] counter_now;
  logic [63:0] new_seconds;
  logic [63:0] new_fraction;

  modport source (output valid, func, clock_id, counter_now, new_seconds, new_fraction,
                  input ready);
  modport sink (input valid, func, clock_id, counter_now, new_seconds, new_fraction,
                output ready);
endinterface

interface ctwc_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [63:0] seconds;
  logic [29:0] subseconds;

  modport source (output valid, status, seconds, subseconds, input ready);
  modport sink (input valid, status, seconds, subseconds, output ready);
endinterface

// ===== sv/counter_to_wall_time_clock.sv =====
`timescale 1ns / 1ps
// Top level: cycle counter to wall time conversion with a base time table.
//
//  Channel  Dir  Handshake        Contents
//  in_i     in   valid/ready      func, clock_id, counter_now, new_seconds, new_fraction
//  out_o    out  valid/ready      status, seconds, subseconds
//  cfg      in   cfg_we_i only    cfg_idx_i selects register, cfg_data_i value
//
// Base entry and reference count writes end as the item is taken. A fallback
// read goes to ST_OUT, a coarse one via ST_MEM, a clock read also via ST_MUL_HI,
// ST_SUM and ST_DIV_NS, and a ToD read ST_DIV_US; the divider does 4 bits/cycle.
// Reset clears the base table through per-entry valid bits, so no clearing pass.
// One item is in work at a time; a result waits in the output register while
// the next item is taken, and the block stalls only when that register is full.
module counter_to_wall_time_clock #(
  parameter int CLOCK_SLOTS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ctwc_in_if.sink                      in_i,
  ctwc_out_if.source                   out_o,
  input  logic                         cfg_we_i,
  input  logic [ctwc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ctwc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ctwc_pkg::*;

  localparam int AW = $clog2(CLOCK_SLOTS);

  // Configuration registers
  logic [31:0] main_mult_q, raw_mult_q;
  logic [5:0]  main_shift_q, raw_shift_q;
  logic        main_mode_q, raw_mode_q;

  // Reference counts and base table valid bits
  logic [62:0]            ref_main_q, ref_raw_q;
  logic [CLOCK_SLOTS-1:0] slot_vld_q;

  state_e state_q, state_d;

  // Decode of the incoming item
  logic        accept, is_read, fallback, in_range;
  kind_e       kind;
  logic [3:0]  eff_id;
  logic [62:0] ref_sel, diff, delta_d;

  // Item registers
  logic [62:0]   delta_q;
  logic          raw_q, coarse_q, tod_q, fb_q;
  logic [AW-1:0] idx_q;
  logic [63:0]   sec_q, frac_q, p_lo_q, acc_q;
  logic [31:0]   p_hi_q;
  logic [29:0]   ns_q;

  // Datapath
  logic [31:0]  mul_sel;
  logic [5:0]   shift_sel;
  logic [63:0]  lo_prod;
  logic [62:0]  hi_prod;
  logic [63:0]  sum_shift;
  logic [127:0] ram_rdata;
  logic [63:0]  ent_sec, ent_frac;
  logic         ram_we, ram_re;

  // Divider
  div_req_t    div_req;
  div_stat_t   div_stat;
  logic [63:0] div_dividend, div_quo;
  logic [29:0] div_rem;

  // Output register
  logic        out_valid_q, out_status_q, out_free, out_load;
  logic [63:0] out_seconds_q;
  logic [29:0] out_sub_q;

  assign accept   = in_i.valid && in_i.ready;
  assign is_read  = (in_i.func == FUNC_READ) || (in_i.func == FUNC_TOD);
  assign in_range = int'(in_i.clock_id) < CLOCK_SLOTS;
  assign eff_id   = (in_i.func == FUNC_TOD) ? CID_REALTIME : in_i.clock_id;

  always_comb begin
    kind = KIND_NONE;
    if (in_i.func == FUNC_TOD) begin
      kind = KIND_MAIN;
    end else if (in_i.func == FUNC_READ) begin
      case (in_i.clock_id) inside
        CID_REALTIME, CID_MONOTONIC, CID_BOOTTIME, CID_TAI: kind = KIND_MAIN;
        CID_RAW:                                            kind = KIND_RAW;
        CID_RT_COARSE, CID_MONO_COARSE:                     kind = KIND_COARSE;
        default:                                            kind = KIND_NONE;
      endcase
    end
  end

  assign fallback = (kind == KIND_NONE) || ((kind == KIND_MAIN) && !main_mode_q) ||
                    ((kind == KIND_RAW) && !raw_mode_q);

  // A delta with bit 62 set is a small backward step and reads as zero.
  assign ref_sel = (kind == KIND_RAW) ? ref_raw_q : ref_main_q;
  assign diff    = in_i.counter_now[62:0] - ref_sel;
  assign delta_d = diff[62] ? '0 : diff;

  assign mul_sel   = raw_q ? raw_mult_q : main_mult_q;
  assign shift_sel = raw_q ? raw_shift_q : main_shift_q;
  assign lo_prod   = delta_q[31:0] * mul_sel;
  assign hi_prod   = delta_q[62:32] * mul_sel;
  assign sum_shift = (acc_q + {p_hi_q, 32'b0}) >> shift_sel;

  // Entries never written since reset read as zero.
  assign ent_sec  = slot_vld_q[idx_q] ? ram_rdata[127:64] : '0;
  assign ent_frac = slot_vld_q[idx_q] ? ram_rdata[63:0] : '0;

  assign out_free = !out_valid_q || out_o.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && is_read) begin
          state_d = fallback ? ST_OUT : ST_MEM;
        end
      end
      ST_MEM:    state_d = coarse_q ? ST_OUT : ST_MUL_HI;
      ST_MUL_HI: state_d = ST_SUM;
      ST_SUM:    state_d = ST_DIV_NS;
      ST_DIV_NS: begin
        if (div_stat.done) begin
          state_d = tod_q ? ST_DIV_US : ST_OUT;
        end
      end
      ST_DIV_US: begin
        if (div_stat.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_i.ready    = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    div_req.start = 1'b0;
    div_req.sel   = DIV_BY_S;
    div_dividend  = sum_shift;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        ram_re     = accept && is_read && !fallback;
        ram_we     = accept && (in_i.func == FUNC_BASE_WR) && in_range;
      end
      ST_SUM: begin
        div_req.start = 1'b1;
      end
      ST_DIV_NS: begin
        div_req.start = div_stat.done && tod_q;
        div_req.sel   = DIV_BY_US;
        div_dividend  = {34'b0, div_rem};
      end
      ST_OUT: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration, reference counts and table valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_mult_q  <= '0;
      main_shift_q <= '0;
      raw_mult_q   <= '0;
      raw_shift_q  <= '0;
      main_mode_q  <= 1'b0;
      raw_mode_q   <= 1'b0;
      ref_main_q   <= '0;
      ref_raw_q    <= '0;
      slot_vld_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MAIN_MULT:  main_mult_q  <= cfg_data_i[31:0];
          CFG_MAIN_SHIFT: main_shift_q <= cfg_data_i[5:0];
          CFG_RAW_MULT:   raw_mult_q   <= cfg_data_i[31:0];
          CFG_RAW_SHIFT:  raw_shift_q  <= cfg_data_i[5:0];
          CFG_MAIN_MODE:  main_mode_q  <= cfg_data_i[0];
          CFG_RAW_MODE:   raw_mode_q   <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      if (accept && (in_i.func == FUNC_REF_WR)) begin
        if (in_i.clock_id == CID_RAW) begin
          ref_raw_q <= in_i.counter_now[62:0];
        end else begin
          ref_main_q <= in_i.counter_now[62:0];
        end
      end
      if (ram_we) begin
        slot_vld_q[AW'(in_i.clock_id)] <= 1'b1;
      end
    end
  end

  // Item datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      delta_q  <= delta_d;
      raw_q    <= (kind == KIND_RAW);
      coarse_q <= (kind == KIND_COARSE);
      tod_q    <= (in_i.func == FUNC_TOD);
      fb_q     <= fallback;
      idx_q    <= AW'(eff_id);
    end
    case (state_q)
      ST_MEM: begin
        sec_q  <= ent_sec;
        frac_q <= ent_frac;
        ns_q   <= ent_frac[29:0];
        p_lo_q <= lo_prod;
      end
      ST_MUL_HI: begin
        p_hi_q <= hi_prod[31:0];
        acc_q  <= frac_q + p_lo_q;
      end
      ST_DIV_NS: begin
        if (div_stat.done) begin
          sec_q <= sec_q + div_quo;
          ns_q  <= div_rem;
        end
      end
      ST_DIV_US: begin
        if (div_stat.done) begin
          ns_q <= div_quo[29:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // A fallback result carries zero time.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q  <= fb_q;
      out_seconds_q <= fb_q ? '0 : sec_q;
      out_sub_q     <= fb_q ? '0 : ns_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.seconds    = out_seconds_q;
  assign out_o.subseconds = out_sub_q;

  ctwc_ram #(
    .WIDTH(128),
    .DEPTH(CLOCK_SLOTS)
  ) u_base_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AW'(in_i.clock_id)),
    .wdata_i({in_i.new_seconds, in_i.new_fraction}),
    .re_i   (ram_re),
    .raddr_i(AW'(eff_id)),
    .rdata_o(ram_rdata)
  );

  ctwc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .stat_o     (div_stat),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) && !(accept && is_read) |=> state_q == ST_IDLE)
    else $error("left idle without a read item");

  a_div_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_NS || state_q == ST_DIV_US) |-> div_stat.busy || div_stat.done)
    else $error("waiting on an idle divider");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == ST_DIV_NS || state_q == ST_DIV_US)
    else $error("divider result arrived outside a division state");

  a_fallback_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q |-> out_seconds_q == '0 && out_sub_q == '0)
    else $error("fallback result carries a nonzero time");

  a_mem_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MEM |-> $past(ram_re))
    else $error("table data used without a read");

endmodule

// ===== sv/ctwc_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
module ctwc_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ctwc_div.sv =====
`timescale 1ns / 1ps
// Iterative divider of a 64-bit value by one second or one microsecond in ns.
module ctwc_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctwc_pkg::div_req_t  req_i,
  input  logic [63:0]         dividend_i,
  output ctwc_pkg::div_stat_t stat_o,
  output logic [63:0]         quotient_o,
  output logic [29:0]         remainder_o
);
  import ctwc_pkg::*;

  localparam int STEP_BITS = 4;
  localparam int STEPS     = 64 / STEP_BITS;
  localparam int CNT_W     = $clog2(STEPS);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  div_sel_e         sel_q;
  logic [63:0]      work_q, work_d;
  logic [SUB_W-1:0] rem_q, rem_d;
  logic [SUB_W-1:0] divisor;
  logic [SUB_W:0]   trial;

  assign divisor = (sel_q == DIV_BY_S) ? NS_PER_S : NS_PER_US;

  // Restoring division, STEP_BITS quotient bits per cycle. The work register
  // shifts the dividend out at the top and the quotient in at the bottom.
  always_comb begin
    work_d = work_q;
    rem_d  = rem_q;
    trial  = '0;
    for (int k = 0; k < STEP_BITS; k++) begin
      trial  = {rem_d, work_d[63]};
      work_d = {work_d[62:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        trial     = trial - {1'b0, divisor};
        work_d[0] = 1'b1;
      end
      rem_d = trial[SUB_W-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sel_q  <= req_i.sel;
      work_q <= dividend_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = work_q;
  assign remainder_o = rem_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("divider done without a finished run");

  a_fell_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> done_q)
    else $error("divider run ended without done");

endmodule

// ===== sim/counter_to_wall_time_clock_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the counter to wall time clock with a built-in time predictor.
module counter_to_wall_time_clock_test;
  import ctwc_pkg::*;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  clock_id;
    logic [63:0] counter_now;
    logic [63:0] new_seconds;
    logic [63:0] new_fraction;
  } request_t;

  typedef struct packed {
    logic        status;
    logic [63:0] seconds;
    logic [29:0] subseconds;
  } reading_t;

  localparam logic [3:0] READ_IDS [7] = '{CID_REALTIME, CID_MONOTONIC, CID_RAW,
                                          CID_RT_COARSE, CID_MONO_COARSE, CID_BOOTTIME,
                                          CID_TAI};

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  ctwc_in_if  in_ch ();
  ctwc_out_if out_ch ();

  counter_to_wall_time_clock #(
    .CLOCK_SLOTS(16)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Predicted state of the block.
  logic [63:0] base_sec_tbl [16];
  logic [63:0] base_frac_tbl [16];
  logic [62:0] main_ref;
  logic [62:0] raw_ref;
  logic [31:0] main_mult_r;
  logic [31:0] raw_mult_r;
  logic [5:0]  main_shift_r;
  logic [5:0]  raw_shift_r;
  logic        main_mode_r;
  logic        raw_mode_r;

  request_t send_queue [$];
  reading_t expected_readings [$];
  request_t next_req;
  reading_t got;
  reading_t want;
  logic     in_fire;
  int       items_queued;
  int       items_taken;
  int       mismatches;
  int       send_idle;
  int       recv_idle;
  int       hold_req;
  int       hold_left;
  logic [63:0] stim_main_ref;
  logic [63:0] stim_raw_ref;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Converts a live count into seconds and nanoseconds on one page.
  function automatic reading_t scale_counter(input logic raw_page, input logic [3:0] slot,
                                             input logic [63:0] now);
    logic [62:0] delta;
    logic [63:0] acc;
    reading_t    r;
    delta = now[62:0] - (raw_page ? raw_ref : main_ref);
    if (delta[62]) begin
      delta = '0;
    end
    acc = base_frac_tbl[slot] + {1'b0, delta} * 64'(raw_page ? raw_mult_r : main_mult_r);
    acc = acc >> (raw_page ? raw_shift_r : main_shift_r);
    r.status = 1'b0;
    r.seconds = base_sec_tbl[slot] + acc / 64'(NS_PER_S);
    r.subseconds = 30'(acc % 64'(NS_PER_S));
    return r;
  endfunction

  task automatic predict_clock(input request_t req);
    reading_t r;
    r = '{status: 1'b1, seconds: '0, subseconds: '0};
    case (req.func)
      FUNC_BASE_WR: begin
        base_sec_tbl[req.clock_id] = req.new_seconds;
        base_frac_tbl[req.clock_id] = req.new_fraction;
      end
      FUNC_REF_WR: begin
        if (req.clock_id == CID_RAW) begin
          raw_ref = req.counter_now[62:0];
        end else begin
          main_ref = req.counter_now[62:0];
        end
      end
      FUNC_TOD: begin
        if (main_mode_r) begin
          r = scale_counter(1'b0, CID_REALTIME, req.counter_now);
          r.subseconds = r.subseconds / NS_PER_US;
        end
      end
      default: begin
        case (req.clock_id)
          CID_REALTIME, CID_MONOTONIC, CID_BOOTTIME, CID_TAI: begin
            if (main_mode_r) begin
              r = scale_counter(1'b0, req.clock_id, req.counter_now);
            end
          end
          CID_RAW: begin
            if (raw_mode_r) begin
              r = scale_counter(1'b1, req.clock_id, req.counter_now);
            end
          end
          CID_RT_COARSE, CID_MONO_COARSE: begin
            r.status = 1'b0;
            r.seconds = base_sec_tbl[req.clock_id];
            r.subseconds = base_frac_tbl[req.clock_id][29:0];
          end
          default: ;
        endcase
      end
    endcase
    if (req.func == FUNC_READ || req.func == FUNC_TOD) begin
      expected_readings.push_back(r);
    end
  endtask

  task automatic note_mismatch(input string field, input logic [63:0] got_v,
                               input logic [63:0] want_v);
    mismatches++;
    if (mismatches <= 100) begin
      $display("%0t ns: %s mismatch, got %h expected %h", $time, field, got_v, want_v);
    end
  endtask

  // Watches both channels: accepted requests feed the predictor, results are checked.
  always @(posedge clk_i) begin
    in_fire <= in_ch.valid && in_ch.ready;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{status: out_ch.status, seconds: out_ch.seconds,
                subseconds: out_ch.subseconds};
        if (expected_readings.size() == 0) begin
          note_mismatch("unexpected result seconds", got.seconds, '0);
        end else begin
          want = expected_readings.pop_front();
          if (got.status !== want.status) begin
            note_mismatch("status", 64'(got.status), 64'(want.status));
          end
          if (got.seconds !== want.seconds) begin
            note_mismatch("seconds", got.seconds, want.seconds);
          end
          if (got.subseconds !== want.subseconds) begin
            note_mismatch("subseconds", 64'(got.subseconds), 64'(want.subseconds));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_clock('{func: in_ch.func, clock_id: in_ch.clock_id,
                        counter_now: in_ch.counter_now, new_seconds: in_ch.new_seconds,
                        new_fraction: in_ch.new_fraction});
        items_taken++;
      end
    end
  end

  // Request driver: presents the next item once the current one is taken.
  always @(negedge clk_i) begin
    if (!in_ch.valid || in_fire) begin
      if (send_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
        next_req = send_queue.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.func <= next_req.func;
        in_ch.clock_id <= next_req.clock_id;
        in_ch.counter_now <= next_req.counter_now;
        in_ch.new_seconds <= next_req.new_seconds;
        in_ch.new_fraction <= next_req.new_fraction;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random back-pressure, plus a long hold when one is requested.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_req > 0) begin
      hold_left <= hold_req;
      hold_req = 0;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic queue_request(input logic [1:0] func, input logic [3:0] id,
                               input logic [63:0] now, input logic [63:0] sec,
                               input logic [63:0] frac);
    while (send_queue.size() >= 4) begin
      @(posedge clk_i);
    end
    send_queue.push_back('{func: func, clock_id: id, counter_now: now, new_seconds: sec,
                           new_fraction: frac});
    items_queued++;
    if (func == FUNC_REF_WR) begin
      if (id == CID_RAW) begin
        stim_raw_ref = now;
      end else begin
        stim_main_ref = now;
      end
    end
  endtask

  // Waits for every item to be taken and answered, then for the longest latency.
  task automatic drain_and_settle();
    while (items_taken != items_queued || expected_readings.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (48) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MAIN_MULT:  main_mult_r = data;
      CFG_MAIN_SHIFT: main_shift_r = data[5:0];
      CFG_RAW_MULT:   raw_mult_r = data;
      CFG_RAW_SHIFT:  raw_shift_r = data[5:0];
      CFG_MAIN_MODE:  main_mode_r = data[0];
      CFG_RAW_MODE:   raw_mode_r = data[0];
      default: ;
    endcase
  endtask

  task automatic set_page_config(input logic [31:0] mm, input logic [5:0] ms,
                                 input logic [31:0] rm, input logic [5:0] rs,
                                 input logic mmode, input logic rmode);
    write_reg(CFG_MAIN_MULT, mm);
    write_reg(CFG_MAIN_SHIFT, 32'(ms));
    write_reg(CFG_RAW_MULT, rm);
    write_reg(CFG_RAW_SHIFT, 32'(rs));
    write_reg(CFG_MAIN_MODE, 32'(mmode));
    write_reg(CFG_RAW_MODE, 32'(rmode));
  endtask

  // Mostly reads close to the latest reference count, mixed with table and
  // reference updates and some fully random items.
  task automatic random_phase(input int count, input int hold_at);
    int          n;
    int          pick;
    logic        tod;
    logic [3:0]  id;
    logic [63:0] now;
    logic [63:0] sec;
    logic [63:0] frac;
    logic [63:0] step;
    logic [63:0] base;
    for (n = 0; n < count; n++) begin
      if (n == hold_at) begin
        @(posedge clk_i);
        hold_req = 240;
      end
      pick = $urandom_range(99);
      id = 4'($urandom_range(15));
      if (pick < 8) begin
        if ($urandom_range(1) == 1) begin
          id = CID_RAW;
        end
        queue_request(FUNC_REF_WR, id, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom});
      end else if (pick < 20) begin
        sec = ($urandom_range(1) == 1) ? {$urandom, $urandom} : 64'($urandom_range(100000));
        frac = ($urandom_range(2) == 0) ? {$urandom, $urandom}
                                        : 64'($urandom_range(999999999));
        queue_request(FUNC_BASE_WR, id, {$urandom, $urandom}, sec, frac);
      end else if (pick < 85) begin
        if ($urandom_range(4) != 0) begin
          id = READ_IDS[$urandom_range(6)];
        end
        tod = ($urandom_range(5) == 0);
        base = (id == CID_RAW && !tod) ? stim_raw_ref : stim_main_ref;
        step = {$urandom, $urandom} >> $urandom_range(20, 63);
        // A few reads land just behind the reference, which the block treats as no progress.
        now = ($urandom_range(9) == 0) ? base - 64'($urandom_range(1, 5000)) : base + step;
        now[63] = 1'($urandom_range(1));
        queue_request(tod ? FUNC_TOD : FUNC_READ, id, now, {$urandom, $urandom},
                      {$urandom, $urandom});
      end else begin
        queue_request(2'($urandom_range(3)), id, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_READ;
    in_ch.clock_id = '0;
    in_ch.counter_now = '0;
    in_ch.new_seconds = '0;
    in_ch.new_fraction = '0;
    out_ch.ready = 1'b0;
    in_fire = 1'b0;
    items_queued = 0;
    items_taken = 0;
    mismatches = 0;
    send_idle = 18;
    recv_idle = 55;
    hold_req = 0;
    hold_left = 0;
    stim_main_ref = '0;
    stim_raw_ref = '0;
    for (int i = 0; i < 16; i++) begin
      base_sec_tbl[i] = '0;
      base_frac_tbl[i] = '0;
    end
    main_ref = '0;
    raw_ref = '0;
    main_mult_r = '0;
    raw_mult_r = '0;
    main_shift_r = '0;
    raw_shift_r = '0;
    main_mode_r = 1'b0;
    raw_mode_r = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: counter modes off, so only coarse clocks give a time.
    queue_request(FUNC_READ, CID_REALTIME, '1, '0, '0);
    queue_request(FUNC_READ, CID_RAW, '0, '0, '0);
    queue_request(FUNC_TOD, 4'd9, '1, '0, '0);
    queue_request(FUNC_READ, CID_RT_COARSE, '0, '0, '0);
    queue_request(FUNC_BASE_WR, CID_RT_COARSE, '0, '1, 64'd999999999);
    queue_request(FUNC_READ, CID_RT_COARSE, '0, '0, '0);
    queue_request(FUNC_BASE_WR, CID_MONO_COARSE, '0, '0, '1);
    queue_request(FUNC_READ, CID_MONO_COARSE, '0, '0, '0);
    queue_request(FUNC_BASE_WR, 4'd15, '0, '1, '1);
    queue_request(FUNC_READ, 4'd15, '1, '1, '1);
    queue_request(FUNC_READ, 4'd2, '0, '0, '0);
    drain_and_settle();

    set_page_config(32'hFFFF_FFFF, 6'd63, 32'd1, 6'd0, 1'b1, 1'b1);
    queue_request(FUNC_REF_WR, CID_RAW, '1, '0, '0);
    queue_request(FUNC_REF_WR, CID_TAI, 64'h8000_0000_0000_0010, '0, '0);
    queue_request(FUNC_BASE_WR, CID_REALTIME, '0, '1, '1);
    queue_request(FUNC_READ, CID_REALTIME, 64'h15, '0, '0);
    queue_request(FUNC_READ, CID_REALTIME, 64'hF, '0, '0);
    // The raw count wraps past the reference: the difference is three counts.
    queue_request(FUNC_READ, CID_RAW, 64'h2, '0, '0);
    queue_request(FUNC_TOD, CID_TAI, 64'h10 + 64'd123456789, '0, '0);
    queue_request(FUNC_READ, CID_MONOTONIC, 64'h10 + (64'd1 << 40), '0, '0);
    queue_request(FUNC_READ, CID_BOOTTIME, 64'h4000_0000_0000_0010, '0, '0);
    queue_request(FUNC_READ, CID_TAI, 64'h3FFF_FFFF_FFFF_FFFF + 64'h10, '0, '0);
    drain_and_settle();

    set_page_config(32'($urandom_range(1 << 22, 1 << 24)), 6'($urandom_range(22, 24)),
                    32'($urandom_range(1 << 22, 1 << 24)), 6'($urandom_range(22, 24)),
                    1'b1, 1'b1);
    random_phase(210, 60);
    drain_and_settle();

    set_page_config(32'd0, 6'd0, 32'hFFFF_FFFF, 6'd63, 1'b0, 1'b1);
    random_phase(210, -1);
    drain_and_settle();

    send_idle = 55;
    recv_idle = 18;
    set_page_config($urandom, 6'($urandom_range(63)), $urandom, 6'($urandom_range(63)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
    random_phase(210, -1);
    drain_and_settle();

    send_idle = 0;
    recv_idle = 0;
    set_page_config(32'($urandom_range(1, 64)), 6'($urandom_range(6)), $urandom,
                    6'($urandom_range(32, 63)), 1'b1, 1'b0);
    random_phase(210, -1);
    drain_and_settle();

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
